/* sv/assert_macros.svh */
// assertion macros used by the merge sort engine sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is asserted
`define MSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("merge sort engine check failed");

// condition that must never hold
`define MSE_NEVER(lbl, expr) `MSE_ASSERT(lbl, !(expr))

`endif

/* sv/mse_pkg.sv */
// shared constants and types of the merge sort engine
package mse_pkg;

  localparam int KEY_W   = 32;
  localparam int MAX_EL  = 64;
  localparam int ADDR_W  = $clog2(MAX_EL);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SPAN_W  = CNT_W + 1;

  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // register word index, taken from paddr above the byte offset
  localparam logic REG_DESC = 1'b0;

  // write and read requests toward the two key buffers
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr_l;
    logic [ADDR_W-1:0] raddr_r;
  } mem_req_t;

endpackage

/* sv/mse_ram.sv */
// generic synchronous ram, one write port and two registered read ports
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and read, read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

/* sv/mse_cfg.sv */
// apb register block holding the sort direction
module mse_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mse_pkg::APB_AW-1:0]  paddr,
  input  logic [mse_pkg::APB_DW-1:0]  pwdata,
  output logic [mse_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic                        desc_o
);
  import mse_pkg::*;

  logic desc_q, desc_d;
  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[APB_AW-1] == REG_DESC);
  assign wr_en  = psel & penable & pwrite & pready & hit;

  // direction register update
  always_comb begin
    desc_d = desc_q;
    if (wr_en) begin
      desc_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else begin
      desc_q <= desc_d;
    end
  end

  // read back
  assign prdata = hit ? {{(APB_DW-1){1'b0}}, desc_q} : '0;
  assign desc_o = desc_q;

endmodule

/* sv/mse_sorter.sv */
// load, bottom-up merge and unload sequencer over two ping-pong key buffers
`include "assert_macros.svh"

module mse_sorter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        desc_i,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [mse_pkg::KEY_W-1:0]   s_key_i,
  input  logic                        s_last_i,
  input  logic [mse_pkg::KEY_W-1:0]   rd_a_l_i,
  input  logic [mse_pkg::KEY_W-1:0]   rd_a_r_i,
  input  logic [mse_pkg::KEY_W-1:0]   rd_b_l_i,
  input  logic [mse_pkg::KEY_W-1:0]   rd_b_r_i,
  output mse_pkg::mem_req_t           mem_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [mse_pkg::KEY_W-1:0]   m_key_o,
  output logic                        m_fin_o,
  output logic                        m_ovf_o
);
  import mse_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] w_q, w_d;
  logic             src_q, src_d;
  logic [CNT_W-1:0] l_q, l_d;
  logic [CNT_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] k_q, k_d;

  logic             ov_q, ov_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic             ofin_q, ofin_d;
  logic             oovf_q, oovf_d;

  logic              acc;
  logic [KEY_W-1:0]  dl, dr;
  logic              goes_first;
  logic              take_l;
  logic [CNT_W-1:0]  k_nx;
  logic [SPAN_W-1:0] two_w;
  logic [SPAN_W-1:0] n_span;
  logic [SPAN_W-1:0] first_hi;
  logic [SPAN_W-1:0] nx_mid;
  logic [SPAN_W-1:0] nx_hi;
  logic              out_load;
  logic              out_fin;

  assign s_tready_o = (state_q == S_LOAD);
  assign acc        = s_tvalid_i & s_tready_o;

  // heads of the two runs come from the current source buffer
  assign dl = src_q ? rd_b_l_i : rd_a_l_i;
  assign dr = src_q ? rd_b_r_i : rd_a_r_i;
  assign goes_first = desc_i ? (dl > dr) : (dl < dr);
  assign take_l = (l_q < mid_q) && ((r_q >= hi_q) || goes_first);

  // run bounds of the first and of the following merges of a pass
  assign k_nx     = k_q + CNT_W'(1);
  assign two_w    = {w_q, 1'b0};
  assign n_span   = SPAN_W'(cnt_q);
  assign first_hi = (two_w > n_span) ? n_span : two_w;
  assign nx_mid   = ((SPAN_W'(hi_q) + SPAN_W'(w_q)) > n_span) ? n_span
                                                              : (SPAN_W'(hi_q) + SPAN_W'(w_q));
  assign nx_hi    = ((SPAN_W'(hi_q) + two_w) > n_span) ? n_span : (SPAN_W'(hi_q) + two_w);

  // result register handshake
  assign out_load = (state_q == S_OUT) && (!ov_q || m_tready_i);
  assign out_fin  = ((l_q + CNT_W'(1)) == cnt_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    w_d     = w_q;
    src_d   = src_q;
    l_d     = l_q;
    r_d     = r_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    k_d     = k_q;
    ov_d    = ov_q;
    okey_d  = okey_q;
    ofin_d  = ofin_q;
    oovf_d  = oovf_q;
    mem_o.we_a  = 1'b0;
    mem_o.we_b  = 1'b0;
    mem_o.waddr = cnt_q[ADDR_W-1:0];
    mem_o.wdata = s_key_i;

    if (ov_q && m_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (acc) begin
          if (cnt_q < CNT_W'(MAX_EL)) begin
            mem_o.we_a = 1'b1;
            cnt_d      = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (s_last_i) begin
            state_d = S_START;
            w_d     = CNT_W'(1);
            src_d   = 1'b0;
          end
        end
      end
      S_START: begin
        // prime the read ports for a pass, or for unloading when sorted
        l_d = '0;
        if (w_q >= cnt_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MERGE;
          r_d     = w_q;
          mid_d   = w_q;
          hi_d    = first_hi[CNT_W-1:0];
          k_d     = '0;
        end
      end
      S_MERGE: begin
        // one element per cycle into the destination buffer
        mem_o.we_a  = src_q;
        mem_o.we_b  = !src_q;
        mem_o.waddr = k_q[ADDR_W-1:0];
        mem_o.wdata = take_l ? dl : dr;
        k_d = k_nx;
        if (take_l) begin
          l_d = l_q + CNT_W'(1);
        end else begin
          r_d = r_q + CNT_W'(1);
        end
        if (k_nx == hi_q) begin
          if (hi_q == cnt_q) begin
            state_d = S_START;
            w_d     = {w_q[CNT_W-2:0], 1'b0};
            src_d   = !src_q;
          end else begin
            l_d   = hi_q;
            mid_d = nx_mid[CNT_W-1:0];
            r_d   = nx_mid[CNT_W-1:0];
            hi_d  = nx_hi[CNT_W-1:0];
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          ov_d   = 1'b1;
          okey_d = dl;
          ofin_d = out_fin;
          oovf_d = out_fin & drop_q;
          l_d    = l_q + CNT_W'(1);
          if (out_fin) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // next pointers address the buffers so data lines up with the registered pointers
    mem_o.raddr_l = l_d[ADDR_W-1:0];
    mem_o.raddr_r = r_d[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      w_q     <= '0;
      src_q   <= 1'b0;
      l_q     <= '0;
      r_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      w_q     <= w_d;
      src_q   <= src_d;
      l_q     <= l_d;
      r_q     <= r_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    okey_q <= okey_d;
    ofin_q <= ofin_d;
    oovf_q <= oovf_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_key_o    = okey_q;
  assign m_fin_o    = ofin_q;
  assign m_ovf_o    = oovf_q;

  `MSE_ASSERT(a_merge_ptr, (state_q == S_MERGE) |-> (l_q <= mid_q && r_q <= hi_q && k_q < hi_q))
  `MSE_NEVER(a_dual_write, mem_o.we_a && mem_o.we_b)
  `MSE_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_EL))
  `MSE_ASSERT(a_final_done, (out_load && out_fin) |=> (state_q == S_LOAD && cnt_q == '0))

endmodule

/* sv/merge_sort_engine.sv */
// merge sort engine top level: register block, sequencer and two key buffers
//
// Keys stream in one per cycle into buffer A until the request flagged with
// tlast; keys past 64 are dropped and reported in tuser of the final result.
// The batch of n keys is then sorted by bottom-up merging, ping-ponging
// between buffers A and B, one element per cycle through the two read ports
// of the source buffer, in ceil(log2 n) passes, each opened by a start step
// that primes the read ports. Results leave one per cycle while
// m_axis_tready is high. The next batch may start loading while the final
// result still waits in the output register.
module merge_sort_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mse_pkg::APB_AW-1:0]  paddr,
  input  logic [mse_pkg::APB_DW-1:0]  pwdata,
  output logic [mse_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // key requests
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] key
  input  logic                        s_axis_tlast,
  // sorted results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // [31:0] sorted_key
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser   // [0] overflow
);
  import mse_pkg::*;

  logic             desc;
  mem_req_t         mem_req;
  logic [KEY_W-1:0] rd_a_l, rd_a_r, rd_b_l, rd_b_r;

  // direction register
  mse_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .desc_o  (desc)
  );

  // sequencer
  mse_sorter u_sorter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (desc),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_key_i    (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .rd_a_l_i   (rd_a_l),
    .rd_a_r_i   (rd_a_r),
    .rd_b_l_i   (rd_b_l),
    .rd_b_r_i   (rd_b_r),
    .mem_o      (mem_req),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_key_o    (m_axis_tdata),
    .m_fin_o    (m_axis_tlast),
    .m_ovf_o    (m_axis_tuser)
  );

  // key buffer, loaded from the stream
  mse_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EL)) u_buf_a (
    .clk_i    (clk_i),
    .we_i     (mem_req.we_a),
    .waddr_i  (mem_req.waddr),
    .wdata_i  (mem_req.wdata),
    .raddr0_i (mem_req.raddr_l),
    .raddr1_i (mem_req.raddr_r),
    .rdata0_o (rd_a_l),
    .rdata1_o (rd_a_r)
  );

  // merge scratch buffer
  mse_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EL)) u_buf_b (
    .clk_i    (clk_i),
    .we_i     (mem_req.we_b),
    .waddr_i  (mem_req.waddr),
    .wdata_i  (mem_req.wdata),
    .raddr0_i (mem_req.raddr_l),
    .raddr1_i (mem_req.raddr_r),
    .rdata0_o (rd_b_l),
    .rdata1_o (rd_b_r)
  );

endmodule
